FILE: sv/stt_pkg.sv
// Shared types, character constants and classification functions of the tokenizer.
`timescale 1ns / 1ps
package stt_pkg;

	// Token classes as they appear on the result stream
	typedef enum logic [4:0] {
		CLS_EOS    = 5'd0,
		CLS_COMMA  = 5'd1,
		CLS_SEMI   = 5'd2,
		CLS_LPAREN = 5'd3,
		CLS_RPAREN = 5'd4,
		CLS_LCURL  = 5'd5,
		CLS_RCURL  = 5'd6,
		CLS_ADD    = 5'd7,
		CLS_SUB    = 5'd8,
		CLS_MUL    = 5'd9,
		CLS_DIV    = 5'd10,
		CLS_LT     = 5'd11,
		CLS_DEF    = 5'd12,
		CLS_IF     = 5'd13,
		CLS_ELSE   = 5'd14,
		CLS_IDENT  = 5'd15,
		CLS_NUMBER = 5'd16,
		CLS_ERROR  = 5'd17
	} tok_class_e;

	// Front-end scanner modes
	typedef enum logic [1:0] {
		M_IDLE,
		M_IDENT,
		M_NUMBER,
		M_HALT
	} scan_mode_e;

	// Back-end emitter states
	typedef enum logic {
		B_IDLE,
		B_RUN
	} back_state_e;

	// Command kinds passed through the queue
	typedef enum logic {
		K_SINGLE,
		K_RUN
	} cmd_kind_e;

	typedef struct packed {
		cmd_kind_e  kind;
		tok_class_e cls;
		logic       last;
	} cmd_t;

	// Source characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_LCURL  = 8'h7B;
	localparam logic [7:0] CH_RCURL  = 8'h7D;

	// Keywords, first character in the upper bits
	localparam logic [23:0] KW_DEF  = "def";
	localparam logic [15:0] KW_IF   = "if";
	localparam logic [31:0] KW_ELSE = "else";

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= CH_LOWER_A && b <= CH_LOWER_Z) || (b >= CH_UPPER_A && b <= CH_UPPER_Z);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= CH_0 && b <= CH_9;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return is_letter(b) || is_digit(b) || b == CH_UNDER;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_LF;
	endfunction

	function automatic logic [3:0] digit_val(input logic [7:0] b);
		logic [7:0] diff;
		diff = b - CH_0;
		return diff[3:0];
	endfunction

	// True when a byte scanned between tokens produces a result of its own
	function automatic logic emits_token(input logic [7:0] b);
		return !is_space(b) && !is_letter(b) && !is_digit(b);
	endfunction

	// Single-byte token class; anything unlisted is an error
	function automatic tok_class_e single_class(input logic [7:0] b);
		tok_class_e c;
		unique case (b)
			CH_NUL:    c = CLS_EOS;
			CH_COMMA:  c = CLS_COMMA;
			CH_SEMI:   c = CLS_SEMI;
			CH_LPAREN: c = CLS_LPAREN;
			CH_RPAREN: c = CLS_RPAREN;
			CH_LCURL:  c = CLS_LCURL;
			CH_RCURL:  c = CLS_RCURL;
			CH_PLUS:   c = CLS_ADD;
			CH_MINUS:  c = CLS_SUB;
			CH_STAR:   c = CLS_MUL;
			CH_SLASH:  c = CLS_DIV;
			CH_LT:     c = CLS_LT;
			default:   c = CLS_ERROR;
		endcase
		return c;
	endfunction

endpackage

FILE: sv/stt_front.sv
// Scanner front end: takes source bytes, tracks scan mode and issues token commands.
`timescale 1ns / 1ps
module stt_front #(
	parameter int IDENT_MAX  = 64,
	parameter int VALUE_BITS = 48,
	parameter int LINE_BITS  = 16,
	localparam int LEN_W     = $clog2(IDENT_MAX),
	localparam int ADDR_W    = $clog2(IDENT_MAX - 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,
	input  logic                  q_full,
	output logic                  push,
	output stt_pkg::cmd_t         cmd,
	output logic [VALUE_BITS-1:0] cmd_value,
	output logic [LINE_BITS-1:0]  cmd_line,
	output logic [LEN_W-1:0]      cmd_len,
	output logic                  wr_en,
	output logic [ADDR_W-1:0]     wr_addr,
	output logic [7:0]            wr_data,
	input  logic                  run_done
);
	import stt_pkg::*;

	localparam int BUF_LEN = IDENT_MAX - 1;

	scan_mode_e            mode_q, mode_d;
	logic                  hold_vld_q;
	logic [7:0]            hold_byte_q;
	logic [LEN_W-1:0]      len_q, len_d;
	logic [VALUE_BITS-1:0] acc_q, acc_d;
	logic [LINE_BITS-1:0]  line_q, line_d;
	logic                  busy_q;
	logic [7:0]            kw_q [4];
	logic                  kw_wr;
	logic                  consume;
	logic                  is_def, is_if, is_else;

	// Multiply by ten and add a digit, sticking at all ones
	function automatic logic [VALUE_BITS-1:0] mac10(input logic [VALUE_BITS-1:0] acc,
		input logic [3:0] d);
		logic [VALUE_BITS+3:0] prod;
		prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (VALUE_BITS + 4)'(d);
		if (prod[VALUE_BITS+3:VALUE_BITS] != 4'b0000)
			return '1;
		return prod[VALUE_BITS-1:0];
	endfunction

	// Keyword match on the first characters of the buffered identifier
	assign is_def  = len_q == LEN_W'(3) && {kw_q[0], kw_q[1], kw_q[2]} == KW_DEF;
	assign is_if   = len_q == LEN_W'(2) && {kw_q[0], kw_q[1]} == KW_IF;
	assign is_else = len_q == LEN_W'(4) && {kw_q[0], kw_q[1], kw_q[2], kw_q[3]} == KW_ELSE;

	assign s_tready = !hold_vld_q || consume;
	assign cmd_line = line_q;
	assign wr_data  = hold_byte_q;

	// Scan the held byte
	always_comb begin
		mode_d    = mode_q;
		len_d     = len_q;
		acc_d     = acc_q;
		line_d    = line_q;
		consume   = 1'b0;
		push      = 1'b0;
		cmd       = '{kind: K_SINGLE, cls: CLS_EOS, last: 1'b1};
		cmd_value = '0;
		cmd_len   = len_q;
		wr_en     = 1'b0;
		wr_addr   = len_q[ADDR_W-1:0];
		kw_wr     = 1'b0;
		if (hold_vld_q) begin
			unique case (mode_q)
				M_HALT: begin
					consume = 1'b1;
				end
				M_IDENT: begin
					if (is_cont(hold_byte_q) && len_q < LEN_W'(BUF_LEN)) begin
						consume = 1'b1;
						wr_en   = 1'b1;
						kw_wr   = len_q < LEN_W'(4);
						len_d   = len_q + LEN_W'(1);
					end else if (!q_full) begin
						// flush the identifier, keep the byte for a rescan
						push     = 1'b1;
						cmd.last = !emits_token(hold_byte_q);
						if (is_def)
							cmd.cls = CLS_DEF;
						else if (is_if)
							cmd.cls = CLS_IF;
						else if (is_else)
							cmd.cls = CLS_ELSE;
						else begin
							cmd.kind = K_RUN;
							cmd.cls  = CLS_IDENT;
						end
						len_d  = '0;
						mode_d = M_IDLE;
					end
				end
				M_NUMBER: begin
					if (is_digit(hold_byte_q)) begin
						consume = 1'b1;
						acc_d   = mac10(acc_q, digit_val(hold_byte_q));
					end else if (!q_full) begin
						push      = 1'b1;
						cmd.cls   = CLS_NUMBER;
						cmd.last  = !emits_token(hold_byte_q);
						cmd_value = acc_q;
						acc_d     = '0;
						mode_d    = M_IDLE;
					end
				end
				M_IDLE: begin
					if (is_space(hold_byte_q)) begin
						consume = 1'b1;
						if (hold_byte_q == CH_LF && line_q != '1)
							line_d = line_q + LINE_BITS'(1);
					end else if (is_letter(hold_byte_q)) begin
						// wait until the previous run has left the buffer
						if (!busy_q) begin
							consume = 1'b1;
							wr_en   = 1'b1;
							kw_wr   = 1'b1;
							len_d   = LEN_W'(1);
							mode_d  = M_IDENT;
						end
					end else if (is_digit(hold_byte_q)) begin
						consume = 1'b1;
						acc_d   = mac10('0, digit_val(hold_byte_q));
						mode_d  = M_NUMBER;
					end else if (!q_full) begin
						push    = 1'b1;
						consume = 1'b1;
						cmd.cls = single_class(hold_byte_q);
						if (cmd.cls == CLS_ERROR)
							mode_d = M_HALT;
					end
				end
			endcase
		end
	end

	// Hold register and scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			hold_vld_q <= 1'b0;
			len_q      <= '0;
			acc_q      <= '0;
			line_q     <= LINE_BITS'(1);
			busy_q     <= 1'b0;
		end else begin
			mode_q <= mode_d;
			len_q  <= len_d;
			acc_q  <= acc_d;
			line_q <= line_d;
			if (s_tvalid && s_tready)
				hold_vld_q <= 1'b1;
			else if (consume)
				hold_vld_q <= 1'b0;
			if (push && cmd.kind == K_RUN)
				busy_q <= 1'b1;
			else if (run_done)
				busy_q <= 1'b0;
		end
	end

	// Byte and keyword characters carry no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			hold_byte_q <= s_tdata;
		if (kw_wr)
			kw_q[len_q[1:0]] <= hold_byte_q;
	end

endmodule

FILE: sv/stt_queue.sv
// Short command queue between the scanner front end and the result emitter.
`timescale 1ns / 1ps
module stt_queue #(
	parameter int WIDTH = 80
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);
	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full     = count_q == (PTR_W + 1)'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = slot_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (PTR_W + 1)'(1);
			else if (pop && !push)
				count_q <= count_q - (PTR_W + 1)'(1);
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: sv/stt_back.sv
// Result emitter: holds the identifier buffer and turns commands into result transfers.
`timescale 1ns / 1ps
module stt_back #(
	parameter int IDENT_MAX  = 64,
	parameter int VALUE_BITS = 48,
	parameter int LINE_BITS  = 16,
	localparam int LEN_W     = $clog2(IDENT_MAX),
	localparam int ADDR_W    = $clog2(IDENT_MAX - 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	output logic                   q_pop,
	input  stt_pkg::cmd_t          cmd,
	input  logic [VALUE_BITS-1:0]  cmd_value,
	input  logic [LINE_BITS-1:0]   cmd_line,
	input  logic [LEN_W-1:0]       cmd_len,
	input  logic                   wr_en,
	input  logic [ADDR_W-1:0]      wr_addr,
	input  logic [7:0]             wr_data,
	output logic                   run_done,
	input  logic                   out_ready,
	output logic                   out_vld,
	output stt_pkg::tok_class_e    out_cls,
	output logic [VALUE_BITS-1:0]  out_value,
	output logic [7:0]             out_char,
	output logic [LINE_BITS-1:0]   out_line,
	output logic                   out_end,
	output logic                   out_last
);
	import stt_pkg::*;

	localparam int BUF_LEN = IDENT_MAX - 1;

	logic [7:0]           mem [BUF_LEN];
	logic [7:0]           rd_data_q;
	logic                 rd_en;
	logic [ADDR_W-1:0]    rd_addr;
	back_state_e          state_q, state_d;
	logic [ADDR_W-1:0]    idx_q, idx_d;
	logic [LEN_W-1:0]     run_len_q;
	logic [LINE_BITS-1:0] run_line_q;
	logic                 run_last_q;
	logic                 run_start;
	logic                 load_single, load_char;
	logic                 out_vld_q;
	logic                 out_free;
	logic                 char_is_end;

	assign out_vld     = out_vld_q;
	assign out_free    = !out_vld_q || out_ready;
	assign char_is_end = LEN_W'(idx_q) + LEN_W'(1) == run_len_q;

	// Identifier buffer, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	// Pick the next command and step through identifier runs
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		q_pop       = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = idx_q;
		run_start   = 1'b0;
		run_done    = 1'b0;
		load_single = 1'b0;
		load_char   = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					if (cmd.kind == K_SINGLE) begin
						if (out_free) begin
							q_pop       = 1'b1;
							load_single = 1'b1;
						end
					end else begin
						q_pop     = 1'b1;
						run_start = 1'b1;
						rd_en     = 1'b1;
						rd_addr   = '0;
						idx_d     = '0;
						state_d   = B_RUN;
					end
				end
			end
			B_RUN: begin
				if (out_free) begin
					load_char = 1'b1;
					if (char_is_end) begin
						run_done = 1'b1;
						state_d  = B_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q + ADDR_W'(1);
						idx_d   = idx_q + ADDR_W'(1);
					end
				end
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (load_single || load_char)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
		end
	end

	// Run descriptor and output payload
	always_ff @(posedge clk) begin
		if (run_start) begin
			run_len_q  <= cmd_len;
			run_line_q <= cmd_line;
			run_last_q <= cmd.last;
		end
		if (load_single) begin
			out_cls   <= cmd.cls;
			out_value <= cmd_value;
			out_char  <= 8'h00;
			out_line  <= cmd_line;
			out_end   <= 1'b1;
			out_last  <= cmd.last;
		end else if (load_char) begin
			out_cls   <= CLS_IDENT;
			out_value <= '0;
			out_char  <= rd_data_q;
			out_line  <= run_line_q;
			out_end   <= char_is_end;
			out_last  <= run_last_q && char_is_end;
		end
	end

endmodule

FILE: sv/source_text_tokenizer_core.sv
// Top level of the source text tokenizer: front end, command queue and result emitter.
//
// Source bytes arrive on the s_* channel, one byte per transfer; byte zero marks end of
// stream. Results leave on the m_* channel, one token or one identifier character per
// transfer, with token_end on m_tlast and last_result on m_tuser.
// In the front end a byte that continues a token or is white space is taken when it is
// scanned, a single-byte token once the command queue has room. A byte that ends an
// identifier or a number is scanned twice: to issue the pending token, then to rescan
// the byte itself. An identifier that is not a keyword leaves the buffer at one
// character per cycle while the receiver takes results, paced by the registered read
// port of the identifier buffer; a letter that opens the next identifier waits until
// that run has been read out. A single-byte token passes the hold register, the
// command queue and the output register on its way to m_tvalid.
// A stalled receiver fills the output register and then the four-entry command queue,
// after which the front end stops taking bytes that would issue a command.
// Reset clears the scan state, sets the line count to one and empties the queue; no
// clearing pass is needed. After an error token every further byte is taken and
// dropped until the next reset.
`timescale 1ns / 1ps
module source_text_tokenizer_core #(
	parameter int IDENT_MAX  = 64,
	parameter int VALUE_BITS = 48,
	parameter int LINE_BITS  = 16,
	localparam int OUT_W     = ((5 + VALUE_BITS + 8 + LINE_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,  // in_byte
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // token_class, number_value, ident_char, line_number
	output logic             m_tlast,  // token_end
	output logic             m_tuser   // last_result
);
	import stt_pkg::*;

	localparam int LEN_W  = $clog2(IDENT_MAX);
	localparam int ADDR_W = $clog2(IDENT_MAX - 1);
	localparam int CMD_W  = $bits(cmd_t);
	localparam int Q_W    = CMD_W + VALUE_BITS + LINE_BITS + LEN_W;

	logic                  f_push;
	cmd_t                  f_cmd;
	logic [VALUE_BITS-1:0] f_value;
	logic [LINE_BITS-1:0]  f_line;
	logic [LEN_W-1:0]      f_len;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [7:0]            wr_data;
	logic                  run_done;
	logic                  q_full, q_empty, q_pop;
	logic [Q_W-1:0]        q_rd;
	cmd_t                  q_cmd;
	tok_class_e            out_cls;
	logic [VALUE_BITS-1:0] out_value;
	logic [7:0]            out_char;
	logic [LINE_BITS-1:0]  out_line;

	stt_front #(
		.IDENT_MAX (IDENT_MAX),
		.VALUE_BITS(VALUE_BITS),
		.LINE_BITS (LINE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (f_push),
		.cmd      (f_cmd),
		.cmd_value(f_value),
		.cmd_line (f_line),
		.cmd_len  (f_len),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.run_done (run_done)
	);

	stt_queue #(
		.WIDTH(Q_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.push_data({f_len, f_line, f_value, f_cmd}),
		.pop      (q_pop),
		.pop_data (q_rd),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Unpack the queue head
	assign q_cmd = cmd_t'(q_rd[CMD_W-1:0]);

	stt_back #(
		.IDENT_MAX (IDENT_MAX),
		.VALUE_BITS(VALUE_BITS),
		.LINE_BITS (LINE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.cmd      (q_cmd),
		.cmd_value(q_rd[CMD_W +: VALUE_BITS]),
		.cmd_line (q_rd[CMD_W + VALUE_BITS +: LINE_BITS]),
		.cmd_len  (q_rd[CMD_W + VALUE_BITS + LINE_BITS +: LEN_W]),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.run_done (run_done),
		.out_ready(m_tready),
		.out_vld  (m_tvalid),
		.out_cls  (out_cls),
		.out_value(out_value),
		.out_char (out_char),
		.out_line (out_line),
		.out_end  (m_tlast),
		.out_last (m_tuser)
	);

	// Pack result fields, lowest field first, zero filled to whole bytes
	assign m_tdata = OUT_W'({out_line, out_char, out_value, out_cls});

endmodule

FILE: sv/stt_checker.sv
// Port-level checks on the tokenizer result stream, bound to the top level.
`timescale 1ns / 1ps
module stt_checker #(
	parameter int VALUE_BITS = 48,
	parameter int LINE_BITS  = 16,
	localparam int OUT_W     = ((5 + VALUE_BITS + 8 + LINE_BITS + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tlast,
	input logic             m_tuser
);
	import stt_pkg::*;

	localparam int LINE_LSB = 5 + VALUE_BITS + 8;

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result changed while stalled");

	// Only identifier characters may continue a token
	a_single_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4:0] != CLS_IDENT |-> m_tlast)
		else $error("non-identifier result without token end");

	// The last result of a byte always closes its token
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("last result in the middle of a token");

	// Value field is zero outside number tokens
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4:0] != CLS_NUMBER |-> m_tdata[5 +: VALUE_BITS] == '0)
		else $error("value on a non-number token");

	// Line count starts at one and never wraps to zero
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[LINE_LSB +: LINE_BITS] != '0)
		else $error("line number zero");

endmodule

bind source_text_tokenizer_core stt_checker #(
	.VALUE_BITS(VALUE_BITS),
	.LINE_BITS (LINE_BITS)
) u_stt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);
